FILE: rtl/rbm_pkg.sv
package rbm_pkg;

   localparam int PAGE_W   = 8;
   localparam int CNT_W    = 9;
   localparam int ADDR_W   = 16;
   localparam int PHYS_W   = 22;
   localparam int OFFSET_W = 14;
   localparam int RAM_W    = 13;

   localparam logic [CNT_W-1:0]  PAGE_COUNT_RESET = 9'd16;
   localparam logic [CNT_W-1:0]  PAGE_COUNT_MAX   = 9'd256;
   localparam logic [ADDR_W-1:0] BANK_REG_BASE    = 16'hFFFC;

   localparam int SAVE_ENABLE_BIT = 3;
   localparam int SAVE_HALF_BIT   = 2;

   typedef enum logic [1:0] {
      TGT_ROM  = 2'd0,
      TGT_RAM  = 2'd1,
      TGT_SAVE = 2'd2,
      TGT_NONE = 2'd3
   } target_type;

   typedef struct packed {
      logic             start;
      logic [PAGE_W-1:0] dividend;
      logic [CNT_W-1:0]  divisor;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [PAGE_W-1:0] remainder;
   } mod_rsp_type;

   function automatic logic [CNT_W-1:0] norm_count(input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] r;
      r = n;
      if (n == '0) begin
         r = {{(CNT_W-1){1'b0}}, 1'b1};
      end else if (n > PAGE_COUNT_MAX) begin
         r = PAGE_COUNT_MAX;
      end
      return r;
   endfunction

endpackage

FILE: rtl/rbm_mod_unit.sv
module rbm_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  rbm_pkg::mod_req_type mod_req,
   output rbm_pkg::mod_rsp_type mod_rsp
);

   localparam int STEP_W = $clog2(rbm_pkg::PAGE_W);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [rbm_pkg::PAGE_W-1:0] rem_ff, rem_in;
   logic [rbm_pkg::PAGE_W-1:0] dvd_ff, dvd_in;
   logic [rbm_pkg::CNT_W-1:0]  dvs_ff, dvs_in;
   logic [rbm_pkg::CNT_W-1:0]  trial;
   logic [rbm_pkg::CNT_W-1:0]  diff;

   // one restoring remainder step per cycle
   assign trial = {rem_ff, dvd_ff[rbm_pkg::PAGE_W-1]};
   assign diff  = trial - dvs_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (mod_req.start) begin
         busy_in = 1'b1;
         step_in = '1;
         rem_in  = '0;
         dvd_in  = mod_req.dividend;
         dvs_in  = mod_req.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[rbm_pkg::PAGE_W-2:0], 1'b0};
         if (trial >= dvs_ff) begin
            rem_in = diff[rbm_pkg::PAGE_W-1:0];
         end else begin
            rem_in = trial[rbm_pkg::PAGE_W-1:0];
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

FILE: rtl/rom_bank_mapper_16k.sv
// ROM bank mapper with 16 KB pages.
// req_ channel: one CPU access per item (operation, cpu_address, write_byte),
// valid/ready. rsp_ channel: target, physical_address, save_ram_used,
// valid/ready, from an output register. csr_write_enable/csr_write_data load
// the ROM page count at any edge; write it only while the block is idle.
// A ROM read reduces the bank register modulo the page count in a shared
// remainder unit, one quotient bit per cycle: 8 steps, after which the result
// passes through ST_DONE into the output register and the block returns to idle.
// Every other item goes from acceptance straight to ST_DONE and then out.
// req_ready is high only in ST_IDLE, also while a result waits in the output register; one item at a time.
// A write to 0xFFFC-0xFFFF loads bank register address&3 after the lookup.
// Reset: page count 16, bank registers 0,0,1,0, save flag clear, no item.
// If the receiver stalls, the result stays in the output register and the
// finished next result waits internally; no new item is taken until it moves.
module rom_bank_mapper_16k (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [rbm_pkg::ADDR_W-1:0]   req_cpu_address,
   input  logic [7:0]                   req_write_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_target,
   output logic [rbm_pkg::PHYS_W-1:0]   rsp_physical_address,
   output logic                         rsp_save_ram_used,
   input  logic                         csr_write_enable,
   input  logic [rbm_pkg::CNT_W-1:0]    csr_write_data
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                        state_ff, state_in;
   logic [rbm_pkg::CNT_W-1:0]        page_count_ff;
   logic [7:0]                       bank_ff [4];
   logic                             save_seen_ff, save_seen_in;
   logic [1:0]                       res_target_ff, res_target_in;
   logic [rbm_pkg::PHYS_W-1:0]       res_phys_ff, res_phys_in;
   logic [rbm_pkg::OFFSET_W-1:0]     offset_ff, offset_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [1:0]                       rsp_target_ff;
   logic [rbm_pkg::PHYS_W-1:0]       rsp_phys_ff;
   logic                             rsp_save_ff;

   rbm_pkg::mod_req_type             mod_req;
   rbm_pkg::mod_rsp_type             mod_rsp;

   logic                             accept;
   logic [2:0]                       slot;
   logic                             is_write;
   logic                             save_on;
   logic                             bank_write;
   logic [1:0]                       bank_sel;
   logic                             load_out;

   assign accept     = req_valid && req_ready;
   assign slot       = req_cpu_address[rbm_pkg::ADDR_W-1 -: 3];
   assign is_write   = req_operation;
   assign save_on    = bank_ff[0][rbm_pkg::SAVE_ENABLE_BIT];
   assign bank_write = is_write && (req_cpu_address >= rbm_pkg::BANK_REG_BASE);
   assign bank_sel   = req_cpu_address[1:0];
   assign load_out   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in         = state_ff;
      res_target_in    = res_target_ff;
      res_phys_in      = res_phys_ff;
      offset_in        = offset_ff;
      save_seen_in     = save_seen_ff;
      mod_req.start    = 1'b0;
      mod_req.dividend = bank_ff[1];
      mod_req.divisor  = rbm_pkg::norm_count(page_count_ff);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               offset_in = req_cpu_address[rbm_pkg::OFFSET_W-1:0];
               state_in  = ST_DONE;
               if (slot inside {[3'd6:3'd7]}) begin
                  res_target_in = rbm_pkg::TGT_RAM;
                  res_phys_in   = rbm_pkg::PHYS_W'(req_cpu_address[rbm_pkg::RAM_W-1:0]);
               end else if (slot inside {[3'd4:3'd5]} && save_on) begin
                  res_target_in = rbm_pkg::TGT_SAVE;
                  res_phys_in   = rbm_pkg::PHYS_W'({bank_ff[0][rbm_pkg::SAVE_HALF_BIT],
                                     req_cpu_address[rbm_pkg::OFFSET_W-1:0]});
               end else if (is_write) begin
                  res_target_in = rbm_pkg::TGT_NONE;
                  res_phys_in   = '0;
               end else begin
                  res_target_in = rbm_pkg::TGT_ROM;
                  mod_req.start = 1'b1;
                  state_in      = ST_CALC;
                  if (slot inside {[3'd0:3'd1]}) begin
                     mod_req.dividend = bank_ff[1];
                  end else if (slot inside {[3'd2:3'd3]}) begin
                     mod_req.dividend = bank_ff[2];
                  end else begin
                     mod_req.dividend = bank_ff[3];
                  end
               end
               if (bank_write && bank_sel == 2'd0 && req_write_byte[rbm_pkg::SAVE_ENABLE_BIT]) begin
                  save_seen_in = 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (mod_rsp.done) begin
               res_phys_in = {mod_rsp.remainder, offset_ff};
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         page_count_ff <= rbm_pkg::PAGE_COUNT_RESET;
         bank_ff[0]    <= 8'd0;
         bank_ff[1]    <= 8'd0;
         bank_ff[2]    <= 8'd1;
         bank_ff[3]    <= 8'd0;
         save_seen_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         save_seen_ff <= save_seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            page_count_ff <= csr_write_data;
         end
         if (accept && bank_write) begin
            bank_ff[bank_sel] <= req_write_byte;
         end
      end
      res_target_ff <= res_target_in;
      res_phys_ff   <= res_phys_in;
      offset_ff     <= offset_in;
      if (load_out) begin
         rsp_target_ff <= res_target_ff;
         rsp_phys_ff   <= res_phys_ff;
         rsp_save_ff   <= save_seen_ff;
      end
   end

   rbm_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign req_ready            = (state_ff == ST_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_target           = rsp_target_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_save_ram_used    = rsp_save_ff;

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> state_ff == ST_CALC)
      else $error("remainder done outside calc");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready right after accept");

   a_save_sticky: assert property (@(posedge clock) disable iff (reset)
      save_seen_ff |=> save_seen_ff)
      else $error("save flag cleared");

   a_rom_page_range: assert property (@(posedge clock) disable iff (reset)
      mod_rsp.done |-> 9'(mod_rsp.remainder) < rbm_pkg::norm_count(page_count_ff))
      else $error("page not reduced");

endmodule

FILE: verif/tb_rom_bank_mapper_16k.sv
`timescale 1ns / 1ps

module tb_rom_bank_mapper_16k;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam int   PAGE_SIZE    = 16384;
   localparam int   MAX_GAP      = 17;
   localparam int   SETTLE       = 16;
   localparam int   PHASES       = 14;
   localparam int   PHASE_ITEMS  = 100;
   localparam int   HOLD_CYCLES  = 200;
   localparam int   CYCLE_LIMIT  = 600000;
   localparam int   PRINT_LIMIT  = 40;

   typedef struct {
      rbm_pkg::target_type           target;
      logic [rbm_pkg::PHYS_W-1:0]    phys;
      logic                          save;
   } map_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_operation;
   logic [rbm_pkg::ADDR_W-1:0]   req_cpu_address;
   logic [7:0]                   req_write_byte;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic [1:0]                   rsp_target;
   logic [rbm_pkg::PHYS_W-1:0]   rsp_physical_address;
   logic                         rsp_save_ram_used;
   logic                         csr_write_enable;
   logic [rbm_pkg::CNT_W-1:0]    csr_write_data;

   // mapper state as predicted
   logic [rbm_pkg::CNT_W-1:0]    page_count;
   logic [7:0]                   bank_reg [4];
   logic                         save_flag;

   map_result_type      expected_maps [$];
   int                  error_count;
   int                  access_count;
   int                  checked_count;
   int                  setting_count;
   int                  cycle_count;
   bit                  tx_idle;
   bit                  rx_idle;
   int                  rsp_hold_cycles;

   rom_bank_mapper_16k i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_operation        (req_operation),
      .req_cpu_address      (req_cpu_address),
      .req_write_byte       (req_write_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_target           (rsp_target),
      .rsp_physical_address (rsp_physical_address),
      .rsp_save_ram_used    (rsp_save_ram_used),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_maps.size());
      $display("status: fail");
      $finish;
   end

   function automatic map_result_type map_access(input logic op,
                                                 input logic [rbm_pkg::ADDR_W-1:0] addr,
                                                 input logic [7:0] data);
      map_result_type r;
      logic [7:0]  bank;
      logic        rom_slot;
      int          pages;
      int          offset;
      bank     = 8'd0;
      rom_slot = 1'b1;
      offset   = int'(addr[13:0]);
      r.target = rbm_pkg::TGT_ROM;
      r.phys   = '0;
      case (addr[15:14])
         2'd0: begin
            bank = bank_reg[1];
         end
         2'd1: begin
            bank = bank_reg[2];
         end
         2'd2: begin
            if (bank_reg[0][rbm_pkg::SAVE_ENABLE_BIT]) begin
               rom_slot = 1'b0;
               r.target = rbm_pkg::TGT_SAVE;
               r.phys   = rbm_pkg::PHYS_W'({bank_reg[0][rbm_pkg::SAVE_HALF_BIT], addr[13:0]});
            end else begin
               bank = bank_reg[3];
            end
         end
         default: begin
            rom_slot = 1'b0;
            r.target = rbm_pkg::TGT_RAM;
            r.phys   = rbm_pkg::PHYS_W'(addr[rbm_pkg::RAM_W-1:0]);
         end
      endcase
      if (rom_slot) begin
         if (op == OP_WRITE) begin
            r.target = rbm_pkg::TGT_NONE;
         end else begin
            pages = int'(page_count);
            if (pages == 0) begin
               pages = 1;
            end else if (pages > 256) begin
               pages = 256;
            end
            r.phys = rbm_pkg::PHYS_W'((int'(bank) % pages) * PAGE_SIZE + offset);
         end
      end
      // bank register loads after the lookup
      if (op == OP_WRITE && addr >= rbm_pkg::BANK_REG_BASE) begin
         bank_reg[addr[1:0]] = data;
         if (addr[1:0] == 2'd0 && data[rbm_pkg::SAVE_ENABLE_BIT]) begin
            save_flag = 1'b1;
         end
      end
      r.save = save_flag;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned exp_v,
                                  input int unsigned got_v);
      if (error_count < PRINT_LIMIT) begin
         $display("mismatch %s: expected 0x%0h got 0x%0h (cycle %0d)", what, exp_v, got_v,
                  cycle_count);
      end
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      map_result_type exp_map;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_maps.size() == 0) begin
            report_mismatch("unexpected item", 0, rsp_target);
         end else begin
            exp_map = expected_maps.pop_front();
            if (rsp_target !== exp_map.target) begin
               report_mismatch("target", exp_map.target, rsp_target);
            end
            if (rsp_physical_address !== exp_map.phys) begin
               report_mismatch("physical_address", exp_map.phys, rsp_physical_address);
            end
            if (rsp_save_ram_used !== exp_map.save) begin
               report_mismatch("save_ram_used", exp_map.save, rsp_save_ram_used);
            end
            checked_count++;
         end
      end
   end

   // receiver: random stall per item while rx_idle, or one long hold when requested
   initial begin : receiver
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_hold_cycles != 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         @(negedge clock);
      end
   end

   task automatic send_access(input logic op, input logic [rbm_pkg::ADDR_W-1:0] addr,
                              input logic [7:0] data);
      int gap;
      gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_cpu_address <= addr;
      req_write_byte  <= data;
      do @(posedge clock); while (!req_ready);
      expected_maps.push_back(map_access(op, addr, data));
      access_count++;
   endtask

   task automatic send_random_access();
      int                         pick;
      logic                       op;
      logic [rbm_pkg::ADDR_W-1:0] addr;
      logic [7:0]                 data;
      pick = $urandom_range(0, 99);
      op   = 1'($urandom);
      addr = rbm_pkg::ADDR_W'($urandom);
      data = 8'($urandom);
      if (pick < 22) begin
         op   = OP_WRITE;
         addr = rbm_pkg::BANK_REG_BASE | rbm_pkg::ADDR_W'($urandom_range(0, 3));
      end else if (pick < 30) begin
         addr = {2'b10, 14'($urandom)};
      end
      send_access(op, addr, data);
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_maps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_page_count(input logic [rbm_pkg::CNT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      page_count = value;
      setting_count++;
   endtask

   task automatic test_reset_map();
      send_access(OP_READ, 16'h0000, 8'h00);
      send_access(OP_READ, 16'h3FFF, 8'hFF);
      send_access(OP_READ, 16'h4000, 8'h00);
      send_access(OP_READ, 16'h7FFF, 8'h00);
      send_access(OP_READ, 16'h8000, 8'h00);
      send_access(OP_READ, 16'hBFFF, 8'h00);
      send_access(OP_READ, 16'hC000, 8'h00);
      send_access(OP_READ, 16'hFFFF, 8'h00);
   endtask

   task automatic test_discarded_writes();
      send_access(OP_WRITE, 16'h0000, 8'hFF);
      send_access(OP_WRITE, 16'h7FFF, 8'h00);
      send_access(OP_WRITE, 16'hA000, 8'h55);
      send_access(OP_WRITE, 16'hE123, 8'hFF);
   endtask

   task automatic test_bank_registers();
      send_access(OP_WRITE, 16'hFFFD, 8'hFF);
      send_access(OP_WRITE, 16'hFFFE, 8'h80);
      send_access(OP_WRITE, 16'hFFFF, 8'h0F);
      send_access(OP_READ, 16'h1234, 8'h00);
      send_access(OP_READ, 16'h4000, 8'h00);
      send_access(OP_READ, 16'h8001, 8'h00);
   endtask

   task automatic test_save_ram();
      send_access(OP_WRITE, 16'hFFFC, 8'h08);
      send_access(OP_READ, 16'h8000, 8'h00);
      send_access(OP_WRITE, 16'hBFFF, 8'hAA);
      send_access(OP_WRITE, 16'hFFFC, 8'h0C);
      send_access(OP_READ, 16'hA000, 8'h00);
      send_access(OP_WRITE, 16'hFFFC, 8'h00);
      send_access(OP_READ, 16'h8000, 8'h00);
   endtask

   task automatic test_random_settings();
      logic [rbm_pkg::CNT_W-1:0] counts [8];
      logic [rbm_pkg::CNT_W-1:0] next_count;
      counts = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd257, 9'd16, 9'd255, 9'd2};
      for (int p = 0; p < PHASES; p++) begin
         wait_all_results();
         next_count = (p < 8) ? counts[p] : rbm_pkg::CNT_W'($urandom);
         write_page_count(next_count);
         tx_idle = (p % 4 != 3);
         rx_idle = (p % 4 != 3);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_access();
         end
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   task automatic test_output_backpressure();
      wait_all_results();
      write_page_count(9'd5);
      tx_idle = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) begin
         send_random_access();
      end
      tx_idle = 1'b1;
      wait_all_results();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_READ;
      req_cpu_address  = '0;
      req_write_byte   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      page_count       = rbm_pkg::PAGE_COUNT_RESET;
      bank_reg         = '{8'd0, 8'd0, 8'd1, 8'd0};
      save_flag        = 1'b0;
      error_count      = 0;
      access_count     = 0;
      checked_count    = 0;
      setting_count    = 0;
      tx_idle          = 1'b1;
      rx_idle          = 1'b1;
      rsp_hold_cycles  = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_map();
      test_discarded_writes();
      test_bank_registers();
      test_save_ram();
      test_output_backpressure();
      test_random_settings();

      wait_all_results();
      repeat (30) @(posedge clock);
      $display("ran %0d accesses, %0d results checked, %0d page-count settings",
               access_count, checked_count, setting_count);
      $display("covered ROM/RAM/save RAM maps, bank writes, discards and a long output stall");
      if (error_count == 0 && expected_maps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: rom_bank_mapper_16k.f
rtl/rbm_pkg.sv
rtl/rbm_mod_unit.sv
rtl/rom_bank_mapper_16k.sv
verif/tb_rom_bank_mapper_16k.sv
